// ----- rtl/pids_pkg.sv -----
// ----------------------------------------------------------------------------
// pids_pkg
// shared constants, codes, types and the chunk popcount for the pids checker
// ----------------------------------------------------------------------------
package pids_pkg;

   // default graph capacity (vertices, also bits per adjacency row)
   localparam int MAX_VERTICES_DEF = 64;

   // fixed field widths of the command and register interfaces
   localparam int VERTEX_W   = 6;
   localparam int KIND_W     = 2;
   localparam int VCOUNT_W   = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

   // register map, word index taken from paddr[2]
   localparam logic REG_VERTEX_COUNT = 1'b0;

   // row bits counted per cycle by the shared counter
   localparam int CHUNK_BITS  = 8;
   localparam int CHUNK_CNT_W = $clog2(CHUNK_BITS + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_EDGE   = 2'd0,
      KIND_MEMBER = 2'd1,
      KIND_CHECK  = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // status of the shared counting unit
   typedef struct packed {
      logic busy;
      logic done;
   } cnt_sts_type;

   function automatic logic [CHUNK_CNT_W-1:0] chunk_popcount(
      input logic [CHUNK_BITS-1:0] bits
   );
      logic [CHUNK_CNT_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < CHUNK_BITS; i++) begin
         sum = sum + CHUNK_CNT_W'(bits[i]);
      end
      return sum;
   endfunction

endpackage

// ----- rtl/pids_ram.sv -----
// ----------------------------------------------------------------------------
// pids_ram
// generic single write port ram with bit write enables and registered read
// ----------------------------------------------------------------------------
module pids_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wmask,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (wmask[i]) begin
               mem[waddr][i] <= wdata[i];
            end
         end
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/pids_count.sv -----
// ----------------------------------------------------------------------------
// pids_count
// shared counting unit: degree and in-set neighbour count of one row,
// one chunk of bits per cycle
// ----------------------------------------------------------------------------
module pids_count #(
   parameter int MAX_VERTICES = pids_pkg::MAX_VERTICES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [MAX_VERTICES-1:0]            deg_row,
   input  logic [MAX_VERTICES-1:0]            ins_row,
   output pids_pkg::cnt_sts_type              sts,
   output logic [$clog2(MAX_VERTICES+1)-1:0]  degree,
   output logic [$clog2(MAX_VERTICES+1)-1:0]  in_set
);

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int NCHUNK = (MAX_VERTICES + pids_pkg::CHUNK_BITS - 1) / pids_pkg::CHUNK_BITS;
   localparam int PAD_W  = NCHUNK * pids_pkg::CHUNK_BITS;
   localparam int CH_W   = $clog2(NCHUNK + 1);

   logic [PAD_W-1:0] deg_sr_ff, deg_sr_in;
   logic [PAD_W-1:0] ins_sr_ff, ins_sr_in;
   logic [CNT_W-1:0] deg_ff, deg_in;
   logic [CNT_W-1:0] ins_ff, ins_in;
   logic [CH_W-1:0]  left_ff, left_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      deg_sr_in = deg_sr_ff;
      ins_sr_in = ins_sr_ff;
      deg_in    = deg_ff;
      ins_in    = ins_ff;
      left_in   = left_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (load) begin
         deg_sr_in = PAD_W'(deg_row);
         ins_sr_in = PAD_W'(ins_row);
         deg_in    = '0;
         ins_in    = '0;
         left_in   = CH_W'(NCHUNK);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         deg_in    = deg_ff + CNT_W'(pids_pkg::chunk_popcount(
                        deg_sr_ff[pids_pkg::CHUNK_BITS-1:0]));
         ins_in    = ins_ff + CNT_W'(pids_pkg::chunk_popcount(
                        ins_sr_ff[pids_pkg::CHUNK_BITS-1:0]));
         deg_sr_in = deg_sr_ff >> pids_pkg::CHUNK_BITS;
         ins_sr_in = ins_sr_ff >> pids_pkg::CHUNK_BITS;
         left_in   = left_ff - 1'b1;
         if (left_ff == CH_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      deg_sr_ff <= deg_sr_in;
      ins_sr_ff <= ins_sr_in;
      deg_ff    <= deg_in;
      ins_ff    <= ins_in;
      left_ff   <= left_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign degree   = deg_ff;
   assign in_set   = ins_ff;

endmodule

// ----- rtl/pids_checker.sv -----
// ----------------------------------------------------------------------------
// pids_checker
// positive influence dominating set checker with minimality test
// ----------------------------------------------------------------------------
//
//  channel | direction | transfer when                       | carries
//  --------+-----------+-------------------------------------+-------------------------
//  req_    | in        | req_tvalid && req_tready            | command kind, vertices
//  rsp_    | out       | rsp_tvalid && rsp_tready            | is_pids, is_minimal
//  csr_    | in/out    | psel && penable && pwrite && pready | vertex_count at 0x0
//
//  add member, clear and ignored edges finish in the idle state; an edge also
//  passes through ST_EDGE2 (one bit write into each of the two adjacency rows)
//  in a check every row goes once through the shared 8-bit-per-cycle counter
//  (read, load, the chunk counts, done), then the second pass reads each vertex
//  and evaluates each member row; a failing vertex or a removable member ends
//  the walk early
//  reset clears the row valid bits and the member set at once, no sweep
//  the result waits in an output register; loads keep flowing while it waits,
//  a further check holds in its last state until the register is free
//
module pids_checker #(
   parameter int MAX_VERTICES = pids_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // command stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // vertex_a[5:0], vertex_b[11:6], zero
   input  logic [pids_pkg::KIND_W-1:0]         req_tuser,  // kind[1:0]
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // is_pids[0], is_minimal[1], zero
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pids_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pids_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pids_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_EDGE2   = 8'b0000_0010,
      ST_P1_RD   = 8'b0000_0100,
      ST_P1_LOAD = 8'b0000_1000,
      ST_P1_CNT  = 8'b0001_0000,
      ST_P2_RD   = 8'b0010_0000,
      ST_P2_EVAL = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   // command fields
   logic [pids_pkg::VERTEX_W-1:0] req_a, req_b;
   pids_pkg::kind_type            req_kind;
   logic                          req_xfer;
   logic                          a_in_range, b_in_range;
   logic [VIDX_W-1:0]             a_idx, b_idx;

   // state
   state_type                        state_ff, state_in;
   logic [pids_pkg::VCOUNT_W-1:0]    vcount_ff, vcount_in;
   logic [MAX_VERTICES-1:0]          rowv_ff, rowv_in;      // adjacency row written since clear
   logic [MAX_VERTICES-1:0]          set_ff, set_in;        // members of D
   logic [MAX_VERTICES-1:0]          crit_ff, crit_in;      // vertex fails if it loses one member
   logic [MAX_VERTICES-1:0]          mask_ff, mask_in;      // vertices in use
   logic [CNT_W-1:0]                 n_ff, n_in;
   logic [CNT_W-1:0]                 idx_ff, idx_in;        // walk index for both passes
   logic [VIDX_W-1:0]                edge_b_ff, edge_b_in;  // second row of a pending edge
   logic [VIDX_W-1:0]                edge_a_ff, edge_a_in;
   logic                             pids_ff, pids_in;
   logic                             minimal_ff, minimal_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_pids_ff, rsp_pids_in;
   logic                             rsp_min_ff, rsp_min_in;
   logic                             rd_valid_ff;

   // ram and counter hookup
   logic                             ram_we;
   logic [VIDX_W-1:0]                ram_waddr, ram_raddr;
   logic [MAX_VERTICES-1:0]          ram_wmask, ram_wdata, ram_rdata;
   logic [MAX_VERTICES-1:0]          row_eff;
   logic                             cnt_load;
   logic [MAX_VERTICES-1:0]          cnt_deg_row, cnt_ins_row;
   pids_pkg::cnt_sts_type            cnt_sts;
   logic [CNT_W-1:0]                 cnt_degree, cnt_in_set;
   logic [VIDX_W-1:0]                idx_lo;
   logic                             walk_last;
   logic                             vtx_fails, vtx_crit, member_needed;
   logic                             csr_write;

   assign req_a      = req_tdata[5:0];
   assign req_b      = req_tdata[11:6];
   assign req_kind   = pids_pkg::kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign a_in_range = 32'(req_a) < 32'(MAX_VERTICES);
   assign b_in_range = 32'(req_b) < 32'(MAX_VERTICES);
   assign a_idx      = VIDX_W'(req_a);
   assign b_idx      = VIDX_W'(req_b);

   assign idx_lo    = idx_ff[VIDX_W-1:0];
   assign walk_last = (idx_ff + 1'b1) == n_ff;
   assign ram_raddr = idx_lo;

   // a row never written since clear reads as all zeros
   assign row_eff     = ram_rdata & {MAX_VERTICES{rd_valid_ff}} & mask_ff;
   assign cnt_deg_row = row_eff;
   assign cnt_ins_row = row_eff & set_ff;

   // pass rule 2*ins >= deg; critical when 2*(ins-1) < deg with ins >= 1
   assign vtx_fails = {1'b0, cnt_in_set, 1'b0} < (CNT_W + 2)'(cnt_degree);
   assign vtx_crit  = (cnt_in_set != '0) &&
                      ((CNT_W + 2)'({cnt_in_set, 1'b0}) < ((CNT_W + 2)'(cnt_degree) + (CNT_W + 2)'(2)));
   assign member_needed = |(row_eff & crit_ff);

   // register port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == pids_pkg::REG_VERTEX_COUNT)
                       ? pids_pkg::CSR_DATA_W'(vcount_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      rowv_in      = rowv_ff;
      set_in       = set_ff;
      crit_in      = crit_ff;
      mask_in      = mask_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      edge_a_in    = edge_a_ff;
      edge_b_in    = edge_b_ff;
      pids_in      = pids_ff;
      minimal_in   = minimal_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pids_in  = rsp_pids_ff;
      rsp_min_in   = rsp_min_ff;
      ram_we       = 1'b0;
      ram_waddr    = a_idx;
      ram_wdata    = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_idx;
      ram_wmask    = ram_wdata;
      cnt_load     = 1'b0;

      if (csr_write && (csr_paddr[2] == pids_pkg::REG_VERTEX_COUNT)) begin
         vcount_in = csr_pwdata[pids_pkg::VCOUNT_W-1:0];
      end

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_kind)
                  pids_pkg::KIND_EDGE: begin
                     if (a_in_range && b_in_range && (req_a != req_b)) begin
                        // row a gets bit b now, row b gets bit a next cycle
                        ram_we         = 1'b1;
                        ram_wmask      = rowv_ff[a_idx] ? ram_wdata : '1;
                        rowv_in[a_idx] = 1'b1;
                        edge_a_in      = a_idx;
                        edge_b_in      = b_idx;
                        state_in       = ST_EDGE2;
                     end
                  end
                  pids_pkg::KIND_MEMBER: begin
                     if (a_in_range) begin
                        set_in[a_idx] = 1'b1;
                     end
                  end
                  pids_pkg::KIND_CLEAR: begin
                     rowv_in = '0;
                     set_in  = '0;
                  end
                  pids_pkg::KIND_CHECK: begin
                     // vertices in use: n = min(vertex_count, MAX_VERTICES)
                     if (32'(vcount_ff) > 32'(MAX_VERTICES)) begin
                        n_in = CNT_W'(MAX_VERTICES);
                     end else begin
                        n_in = CNT_W'(vcount_ff);
                     end
                     for (int i = 0; i < MAX_VERTICES; i++) begin
                        mask_in[i] = 32'(i) < 32'(n_in);
                     end
                     idx_in     = '0;
                     pids_in    = 1'b1;
                     minimal_in = 1'b1;
                     state_in   = (n_in == '0) ? ST_DONE : ST_P1_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE2: begin
            ram_we             = 1'b1;
            ram_waddr          = edge_b_ff;
            ram_wdata          = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << edge_a_ff;
            ram_wmask          = rowv_ff[edge_b_ff] ? ram_wdata : '1;
            rowv_in[edge_b_ff] = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_P1_RD: begin
            state_in = ST_P1_LOAD;
         end
         ST_P1_LOAD: begin
            cnt_load = 1'b1;
            state_in = ST_P1_CNT;
         end
         ST_P1_CNT: begin
            if (cnt_sts.done) begin
               crit_in[idx_lo] = vtx_crit;
               if (vtx_fails) begin
                  pids_in    = 1'b0;
                  minimal_in = 1'b0;
                  state_in   = ST_DONE;
               end else if (walk_last) begin
                  idx_in   = '0;
                  state_in = ST_P2_RD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_P1_RD;
               end
            end
         end
         ST_P2_RD: begin
            // only members of D need their row
            if (set_ff[idx_lo]) begin
               state_in = ST_P2_EVAL;
            end else if (walk_last) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_P2_EVAL: begin
            if (!member_needed) begin
               minimal_in = 1'b0;
               state_in   = ST_DONE;
            end else if (walk_last) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_P2_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pids_in  = pids_ff;
               rsp_min_in   = minimal_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= pids_pkg::VCOUNT_RESET;
         rowv_ff      <= '0;
         set_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rowv_ff      <= rowv_in;
         set_ff       <= set_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      crit_ff     <= crit_in;
      mask_ff     <= mask_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      edge_a_ff   <= edge_a_in;
      edge_b_ff   <= edge_b_in;
      pids_ff     <= pids_in;
      minimal_ff  <= minimal_in;
      rsp_pids_ff <= rsp_pids_in;
      rsp_min_ff  <= rsp_min_in;
      rd_valid_ff <= rowv_ff[ram_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_min_ff, rsp_pids_ff};

   // adjacency matrix, one row per vertex
   pids_ram #(
      .WIDTH (MAX_VERTICES),
      .DEPTH (MAX_VERTICES)
   ) u_adj_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wmask (ram_wmask),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared degree / in-set counter
   pids_count #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_count (
      .clock   (clock),
      .reset   (reset),
      .load    (cnt_load),
      .deg_row (cnt_deg_row),
      .ins_row (cnt_ins_row),
      .sts     (cnt_sts),
      .degree  (cnt_degree),
      .in_set  (cnt_in_set)
   );

   // a minimal answer is only ever given together with a passing one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pids_ff || !rsp_min_ff))
      else $error("is_minimal set without is_pids");

   // clear empties the graph and the member set by the cycle after its transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_kind == pids_pkg::KIND_CLEAR)) |=> (rowv_ff == '0 && set_ff == '0))
      else $error("clear did not empty graph and set");

   // the counter is never restarted while it still works on a row
   assert property (@(posedge clock) disable iff (reset)
      cnt_load |-> !cnt_sts.busy)
      else $error("counter loaded while busy");

   // the matrix is written only by edge loads
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE || state_ff == ST_EDGE2))
      else $error("adjacency write outside edge load");

   // second half of an edge follows an accepted edge transfer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDGE2) |-> $past(req_xfer && (req_kind == pids_pkg::KIND_EDGE)))
      else $error("edge second write without edge transfer");

endmodule
